// ===== rtl/smfd_pkg.sv =====
// Shared constants, coefficient table and saturation helper for the
// stereo mix / 9-tap FIR / decimate-by-three block. No dependencies.
package smfd_pkg;

  localparam int TAP_COUNT          = 9;
  localparam int DECIMATION_DEFAULT = 3;
  localparam int SAMPLE_W           = 16;
  localparam int COEF_W             = 13;
  localparam int ACC_W              = 32;
  localparam int COEF_SHIFT         = 14;
  localparam int ADDR_W             = $clog2(TAP_COUNT);
  localparam int PROD_W             = SAMPLE_W + COEF_W;
  localparam int SHIFTED_W          = ACC_W - COEF_SHIFT;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  // Low-pass coefficients, oldest tap first
  function automatic coef_t coef_lookup(input addr_t idx);
    coef_t c;
    begin
      unique case (idx)
        4'd0:    c = 13'sd512;
        4'd1:    c = 13'sd1024;
        4'd2:    c = 13'sd2048;
        4'd3:    c = 13'sd3072;
        4'd4:    c = 13'sd3584;
        4'd5:    c = 13'sd3072;
        4'd6:    c = 13'sd2048;
        4'd7:    c = 13'sd1024;
        4'd8:    c = 13'sd512;
        default: c = '0;
      endcase
      return c;
    end
  endfunction

  // Floor shift by COEF_SHIFT, then clamp to the signed sample range
  function automatic sample_t shift_saturate(input acc_t acc);
    logic signed [SHIFTED_W-1:0] shifted;
    sample_t                     res;
    begin
      shifted = acc[ACC_W-1:COEF_SHIFT];
      if (shifted > SHIFTED_W'(32767))
        res = sample_t'(16'h7FFF);
      else if (shifted < -SHIFTED_W'(32768))
        res = sample_t'(16'h8000);
      else
        res = shifted[SAMPLE_W-1:0];
      return res;
    end
  endfunction

endpackage

// ===== rtl/stereo_mix_fir_decimate_by_three.sv =====
// Stereo-to-mono mixer with a 9-tap low-pass FIR and decimation.
// Depends on smfd_pkg (constants, coefficient table, saturation).
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  input    | in_valid / in_ready  | left_sample, right_sample (s16)
//  output   | out_valid / out_ready| filtered_sample (s16)
//
// A request that does not complete a decimation period is taken while idle. Every
// DECIMATION-th request starts a 9-read pass over the history memory through one
// shared multiplier; the result is loaded in the finish state, and no request is
// taken until then. rst (synchronous) clears the valid bits, pointers and counters;
// unwritten history reads as zero. A stalled output only holds the block once a
// new result is ready and the register is occupied.
module stereo_mix_fir_decimate_by_three #(
  parameter int DECIMATION = smfd_pkg::DECIMATION_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  smfd_pkg::sample_t     left_sample,
  input  smfd_pkg::sample_t     right_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output smfd_pkg::sample_t     filtered_sample
);
  import smfd_pkg::*;

  localparam int PH_W = $clog2(DECIMATION + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t                   state;
  addr_t                    wp;
  addr_t                    wp_next;
  logic [PH_W-1:0]          phase;
  logic [TAP_COUNT-1:0]     hist_valid;
  addr_t                    rd_ptr;
  addr_t                    tap;

  // Read and multiply pipeline
  logic                     rd_vld;
  logic                     rd_last;
  logic                     rd_ok;
  addr_t                    rd_tap;
  sample_t                  rd_data;
  logic                     prod_vld;
  logic                     prod_last;
  logic signed [PROD_W-1:0] prod;
  acc_t                     acc;

  sample_t                  mem [TAP_COUNT];

  logic                     accept;
  logic                     emit;
  logic signed [SAMPLE_W:0] mix_sum;
  logic signed [SAMPLE_W:0] mix_adj;
  sample_t                  mono;
  sample_t                  tap_sample;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (phase == PH_W'(DECIMATION - 1));

  // Mix to mono, truncating toward zero
  assign mix_sum = {left_sample[SAMPLE_W-1], left_sample}
                 + {right_sample[SAMPLE_W-1], right_sample};
  assign mix_adj = mix_sum + {{SAMPLE_W{1'b0}}, mix_sum[SAMPLE_W]};
  assign mono    = mix_adj[SAMPLE_W:1];

  assign wp_next = (wp == ADDR_W'(TAP_COUNT - 1)) ? '0 : wp + 1'b1;

  // Never-written history entries read as zero
  assign tap_sample = rd_ok ? rd_data : '0;

  // History memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[wp] <= mono;
    end
    if (state == S_RUN) begin
      rd_data <= mem[rd_ptr];
    end
  end

  // Control, MAC pipeline and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wp         <= '0;
      phase      <= '0;
      hist_valid <= '0;
      rd_ptr     <= '0;
      tap        <= '0;
      rd_vld     <= 1'b0;
      rd_last    <= 1'b0;
      prod_vld   <= 1'b0;
      prod_last  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // the finish state reloads the register itself
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      // Read stage bookkeeping
      rd_vld  <= (state == S_RUN);
      rd_last <= (state == S_RUN) && (tap == ADDR_W'(TAP_COUNT - 1));
      rd_tap  <= tap;
      rd_ok   <= hist_valid[rd_ptr];

      // Multiply stage
      prod_vld  <= rd_vld;
      prod_last <= rd_last;
      prod      <= tap_sample * coef_lookup(rd_tap);

      // Accumulate stage
      if (prod_vld) begin
        acc <= acc + ACC_W'(prod);
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            hist_valid[wp] <= 1'b1;
            wp             <= wp_next;
            if (emit) begin
              phase  <= '0;
              rd_ptr <= wp_next;
              tap    <= '0;
              acc    <= '0;
              state  <= S_RUN;
            end else begin
              phase <= phase + 1'b1;
            end
          end
        end
        S_RUN: begin
          rd_ptr <= (rd_ptr == ADDR_W'(TAP_COUNT - 1)) ? '0 : rd_ptr + 1'b1;
          tap    <= tap + 1'b1;
          if (tap == ADDR_W'(TAP_COUNT - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (prod_vld && prod_last) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            filtered_sample <= shift_saturate(acc);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
